/* design/dq_pkg.sv */
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_STATUS
  } op_kind_e;

  typedef enum logic {
    FE_IDLE,
    FE_LIST
  } fe_state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] push_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               last;
  } out_rsp_t;

  typedef struct packed {
    op_kind_e              kind;
    logic [IDX_W-1:0]      addr;
    logic [WORD_WIDTH-1:0] wdata;
    status_e               status;
    logic                  last;
  } op_t;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(idx) + (CNT_W + 1)'(k);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

endpackage

/* design/dq_ram.sv */
module dq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dq_front.sv */
module dq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dq_pkg::in_req_t in_req_i,
  output logic            op_push_o,
  output dq_pkg::op_t     op_o,
  input  logic            opq_full_i
);
  import dq_pkg::*;

  fe_state_e        state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] list_pos_q, list_pos_d;
  logic [CNT_W-1:0] list_left_q, list_left_d;
  logic             accept;
  logic [31:0]      raw_word;

  assign raw_word = in_req_i.push_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FE_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      list_pos_q  <= '0;
      list_left_q <= '0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      list_pos_q  <= list_pos_d;
      list_left_q <= list_left_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    list_pos_d  = list_pos_q;
    list_left_d = list_left_q;
    in_stall_o  = (state_q == FE_LIST) || opq_full_i;
    accept      = in_valid_i && !in_stall_o;
    op_push_o   = 1'b0;
    op_o.kind   = OP_STATUS;
    op_o.addr   = '0;
    op_o.wdata  = WORD_WIDTH'(raw_word);
    op_o.status = ST_OK;
    op_o.last   = 1'b1;

    unique case (state_q)
      FE_IDLE: begin
        if (accept) begin
          case (in_req_i.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              op_push_o = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                op_o.status = ST_FULL;
              end else begin
                op_o.kind = OP_WRITE;
                if (in_req_i.cmd == CMD_PUSH_FRONT) begin
                  op_o.addr = ring_prev(front_q);
                  front_d   = ring_prev(front_q);
                end else begin
                  op_o.addr = ring_add(front_q, count_q);
                end
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              op_push_o = 1'b1;
              if (count_q == '0) begin
                op_o.status = ST_EMPTY;
              end else begin
                op_o.kind = OP_READ;
                if (in_req_i.cmd == CMD_POP_FRONT) begin
                  op_o.addr = front_q;
                  front_d   = ring_next(front_q);
                end else begin
                  op_o.addr = ring_add(front_q, count_q - CNT_W'(1));
                end
                count_d = count_q - CNT_W'(1);
              end
            end
            CMD_LIST: begin
              if (count_q == '0) begin
                op_push_o   = 1'b1;
                op_o.status = ST_EMPTY;
              end else begin
                state_d     = FE_LIST;
                list_pos_d  = front_q;
                list_left_d = count_q;
              end
            end
            default: ;
          endcase
        end
      end
      FE_LIST: begin
        if (!opq_full_i) begin
          op_push_o   = 1'b1;
          op_o.kind   = OP_READ;
          op_o.addr   = list_pos_q;
          op_o.last   = (list_left_q == CNT_W'(1));
          list_pos_d  = ring_next(list_pos_q);
          list_left_d = list_left_q - CNT_W'(1);
          if (list_left_q == CNT_W'(1)) begin
            state_d = FE_IDLE;
          end
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FE_LIST |-> list_left_q != '0 && list_left_q <= count_q)
    else $error("list walk out of range");

  a_list_holds_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FE_LIST |=> $stable(count_q) && $stable(front_q))
    else $error("pointers moved during list");

endmodule

/* design/dq_opq.sv */
module dq_opq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  dq_pkg::op_t op_i,
  output logic        full_o,
  input  logic        pop_i,
  output dq_pkg::op_t op_o,
  output logic        empty_o
);
  import dq_pkg::*;

  op_t                  buf_q [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] head_q, tail_q;
  logic [OPQ_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign op_o    = buf_q[head_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[tail_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        tail_q <= tail_q + OPQ_PTR_W'(1);
      end
      if (pop_i) begin
        head_q <= head_q + OPQ_PTR_W'(1);
      end
      cnt_q <= cnt_q + OPQ_CNT_W'(push_i) - OPQ_CNT_W'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full op queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty op queue");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OPQ_PTR_W'(head_q + OPQ_PTR_W'(cnt_q)) == tail_q)
    else $error("op queue pointers disagree with count");

endmodule

/* design/dq_back.sv */
module dq_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dq_pkg::op_t      op_i,
  input  logic             opq_empty_i,
  output logic             opq_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dq_pkg::out_rsp_t out_rsp_o
);
  import dq_pkg::*;

  logic                  s1_valid_q;
  op_kind_e              s1_kind_q;
  status_e               s1_status_q;
  logic                  s1_last_q;
  logic                  out_valid_q;
  out_rsp_t              out_rsp_q;
  logic                  out_free;
  logic                  s1_move;
  logic [WORD_WIDTH-1:0] rdata;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign s1_move   = s1_valid_q && out_free;
  assign opq_pop_o = !opq_empty_i && (!s1_valid_q || s1_move);

  dq_ram #(
    .Width(WORD_WIDTH),
    .Depth(DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (opq_pop_o && op_i.kind == OP_WRITE),
    .waddr_i(op_i.addr),
    .wdata_i(op_i.wdata),
    .re_i   (opq_pop_o && op_i.kind == OP_READ),
    .raddr_i(op_i.addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (opq_pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (opq_pop_o) begin
      s1_kind_q   <= op_i.kind;
      s1_status_q <= op_i.status;
      s1_last_q   <= op_i.last;
    end
    if (s1_move) begin
      out_rsp_q.out_value <= (s1_kind_q == OP_READ) ? 32'(rdata) : '0;
      out_rsp_q.status    <= s1_status_q;
      out_rsp_q.last      <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && $stable(s1_kind_q))
    else $error("stage one dropped while output stalled");

  a_ram_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move && !opq_pop_o |=> $stable(rdata))
    else $error("read data changed under stalled stage");

  a_status_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rsp_q.status != ST_OK |-> out_rsp_q.out_value == '0)
    else $error("nonzero word on error result");

endmodule

/* design/double_ended_queue_core.sv */
// Bounded double-ended queue of signed words (DEPTH slots in a ring store).
// Input channel: in_valid_i / in_stall_o with in_req_i = {cmd, push_value}.
//   cmd 0 push front, 1 push back, 2 pop front, 3 pop back, 4 list all;
//   codes 5 to 7 are taken and dropped with no result.
// Output channel: out_valid_o / out_stall_i with out_rsp_o =
//   {out_value, status, last}; status 0 ok, 1 empty, 2 full (push dropped).
// Push and pop give one result each, with last set. List gives one result
// per stored word, front to back, last set on the final one; an empty list
// gives a single empty result.
// Path: an accepted push or pop enters the operation queue, then the stage
//   at the slot store, then the output register; list reads are queued
//   from the list state of the front end, not when the list is accepted.
// Throughput: one push or pop request per cycle while the operation queue
// has room. A list keeps in_stall_o high while the front end walks the ring.
// A four-entry operation queue between the front end and the store lets
// each side stall on its own; a stalled output holds its result and fills
// that queue, after which in_stall_o rises.
// Reset empties the queue (front index and count to zero) and is
// asynchronous, active low; slot contents are not cleared.
module double_ended_queue_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dq_pkg::in_req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dq_pkg::out_rsp_t out_rsp_o
);
  import dq_pkg::*;

  logic op_push;
  op_t  op_in;
  op_t  op_out;
  logic opq_full;
  logic opq_empty;
  logic opq_pop;

  dq_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i  (in_req_i),
    .op_push_o (op_push),
    .op_o      (op_in),
    .opq_full_i(opq_full)
  );

  dq_opq u_opq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_push),
    .op_i   (op_in),
    .full_o (opq_full),
    .pop_i  (opq_pop),
    .op_o   (op_out),
    .empty_o(opq_empty)
  );

  dq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_out),
    .opq_empty_i(opq_empty),
    .opq_pop_o  (opq_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule
